>>> rtl/core/amx_pkg.sv
// Shared constants, opcodes and handshake structs for the accumulator machine execute unit.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package amx_pkg;

    localparam int MEMORY_WORDS_DEF = 100;

    localparam int WORD_W     = 15;                 // signed data word
    localparam int OP_W       = 7;
    localparam int FIELD_AW   = 7;                  // address field of the input word
    localparam int MAG_W      = WORD_W - 1;         // magnitude of an in-range word
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;
    localparam int VALUE_LIMIT = 'h3FFF;            // largest magnitude of a legal word

    localparam logic [OP_W-1:0] OP_READ  = 7'h10;
    localparam logic [OP_W-1:0] OP_WRITE = 7'h11;
    localparam logic [OP_W-1:0] OP_LOAD  = 7'h20;
    localparam logic [OP_W-1:0] OP_STORE = 7'h21;
    localparam logic [OP_W-1:0] OP_ADD   = 7'h30;
    localparam logic [OP_W-1:0] OP_SUB   = 7'h31;
    localparam logic [OP_W-1:0] OP_DIV   = 7'h32;
    localparam logic [OP_W-1:0] OP_MUL   = 7'h33;
    localparam logic [OP_W-1:0] OP_JUMP  = 7'h40;
    localparam logic [OP_W-1:0] OP_JNEG  = 7'h41;
    localparam logic [OP_W-1:0] OP_JZ    = 7'h42;
    localparam logic [OP_W-1:0] OP_HALT  = 7'h43;
    localparam logic [OP_W-1:0] OP_JNS   = 7'h55;
    localparam logic [OP_W-1:0] OP_JC    = 7'h57;
    localparam logic [OP_W-1:0] OP_JP    = 7'h58;
    localparam logic [OP_W-1:0] OP_SHL   = 7'h60;
    localparam logic [OP_W-1:0] OP_SHR   = 7'h61;

    // start request to the shift/add unit
    typedef struct packed {
        logic             start;
        logic             is_div;
        logic [MAG_W-1:0] a_mag;    // multiplier or dividend
        logic [MAG_W-1:0] b_mag;    // multiplicand or divisor
    } iter_req_t;

    // completion from the shift/add unit
    typedef struct packed {
        logic               done;
        logic [2*MAG_W-1:0] product;
        logic [MAG_W-1:0]   quotient;
    } iter_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/amx_mem.sv
// Data memory of the accumulator machine: one write port, one registered read port.
// Per-word valid bits make unwritten words read as zero after reset. Uses amx_pkg.
`default_nettype none

module amx_mem #(
    parameter int MEMORY_WORDS = amx_pkg::MEMORY_WORDS_DEF,
    localparam int ADDR_W      = $clog2(MEMORY_WORDS)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        rd_en,
    input  wire logic [ADDR_W-1:0]           rd_addr,
    input  wire logic                        wr_en,
    input  wire logic [ADDR_W-1:0]           wr_addr,
    input  wire logic [amx_pkg::WORD_W-1:0]  wr_data,
    output logic      [amx_pkg::WORD_W-1:0]  rd_data
);
    import amx_pkg::*;

    logic [WORD_W-1:0]       mem_reg [MEMORY_WORDS];
    logic [MEMORY_WORDS-1:0] valid_reg;
    logic [WORD_W-1:0]       rd_word_reg;
    logic                    rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

`default_nettype wire

>>> rtl/core/amx_iter.sv
// Shared shift/add unit: unsigned multiply or restoring divide of 14-bit magnitudes,
// one bit per cycle through a single adder. Uses amx_pkg.
`default_nettype none

module amx_iter (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire amx_pkg::iter_req_t req,
    output amx_pkg::iter_rsp_t      rsp
);
    import amx_pkg::*;

    localparam int CNT_W = $clog2(MAG_W + 1);
    localparam int SUM_W = 2 * MAG_W + 1;

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                is_div_reg;
    logic [2*MAG_W-1:0]  work_reg;     // partial product or remainder
    logic [MAG_W-1:0]    sh_reg;       // multiplier bits out / dividend out, quotient in
    logic [MAG_W-1:0]    op_reg;

    logic                bit_in;
    logic [2*MAG_W-1:0]  step_x;
    logic [SUM_W-1:0]    step_y;
    logic [SUM_W-1:0]    step_sum;
    logic                step_neg;

    always_comb
    begin
        bit_in   = sh_reg[MAG_W-1];
        step_x   = {work_reg[2*MAG_W-2:0], is_div_reg & bit_in};
        if (is_div_reg)
        begin
            step_y = ~{{(MAG_W+1){1'b0}}, op_reg} + SUM_W'(1);
        end
        else
        begin
            step_y = bit_in ? {{(MAG_W+1){1'b0}}, op_reg} : '0;
        end
        step_sum = {1'b0, step_x} + step_y;
        step_neg = step_sum[SUM_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
            is_div_reg <= 1'b0;
            work_reg   <= '0;
            sh_reg     <= '0;
            op_reg     <= '0;
        end
        else if (req.start)
        begin
            busy_reg   <= 1'b1;
            done_reg   <= 1'b0;
            cnt_reg    <= CNT_W'(MAG_W);
            is_div_reg <= req.is_div;
            work_reg   <= '0;
            sh_reg     <= req.a_mag;
            op_reg     <= req.b_mag;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            if (!is_div_reg)
            begin
                work_reg <= step_sum[2*MAG_W-1:0];
                sh_reg   <= {sh_reg[MAG_W-2:0], 1'b0};
            end
            else if (!step_neg)
            begin
                work_reg <= step_sum[2*MAG_W-1:0];
                sh_reg   <= {sh_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                work_reg <= step_x;
                sh_reg   <= {sh_reg[MAG_W-2:0], 1'b0};
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.product  = work_reg;
    assign rsp.quotient = sh_reg;

endmodule

`default_nettype wire

>>> rtl/core/accumulator_machine_execute_unit_core.sv
// Top level of the accumulator machine execute unit: sequencer, machine state, output register.
// Instantiates amx_mem (data memory) and amx_iter (shift/add unit); uses amx_pkg.
//
// Usage
//   Slave channel (s_*): one word per decoded instruction or host preload.
//     s_tuser is the kind (0 execute, 1 preload of memory word).
//   Master channel (m_*): exactly one result word per accepted input word, in order.
//   Sequence: the memory read is issued at acceptance and the word is there the
//     next cycle. Simple instructions then execute in ST_FETCH, pass ST_DONE and
//     their result is registered in the output register. MUL and DIV run through
//     the shared shift/add unit at one bit per cycle (14 steps) in ST_WAIT.
//     s_tready is high only while the sequencer is idle, so a new word is taken
//     only after the last one has left ST_DONE; the multiply/divide loop sets the
//     worst case.
//   Stalls: the result waits in the output register while m_tready is low; the
//     next word is still accepted and executed, and its result waits until the
//     register is free.
//   Reset: accumulator, add flag and halt flag clear; the valid bits of the data
//     memory clear at once, so every word reads as zero until written.
//   Once halted, words are consumed and answered with halted_out set and no
//     change to the machine state, until the next reset.
`default_nettype none

module accumulator_machine_execute_unit_core #(
    parameter int MEMORY_WORDS = amx_pkg::MEMORY_WORDS_DEF,
    localparam int ADDR_W      = $clog2(MEMORY_WORDS)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // opcode[6:0], address[13:7], data_value[28:14], zero[31:29]
    input  wire logic [amx_pkg::S_TDATA_W-1:0] s_tdata,
    // kind[0]
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // accumulator_out[14:0], jump_taken[15], jump_target[22:16], overflow[23],
    // divide_by_zero[24], bad_opcode[25], halted_out[26], print_valid[27],
    // print_value[42:28], zero[47:43]
    output logic      [amx_pkg::M_TDATA_W-1:0] m_tdata
);
    import amx_pkg::*;

    localparam logic [FIELD_AW:0]       DEPTH   = (FIELD_AW + 1)'(MEMORY_WORDS);
    localparam logic signed [WORD_W:0]  LIM_POS = (WORD_W + 1)'(VALUE_LIMIT);
    localparam logic signed [WORD_W:0]  LIM_NEG = -LIM_POS;
    localparam logic [WORD_W-1:0]       MIN_WORD = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,     // memory word available, execute
        ST_WAIT,      // shift/add unit running
        ST_DONE       // result ready for the output register
    } state_t;

    typedef struct packed {
        logic                jt;
        logic [FIELD_AW-1:0] jtarget;
        logic                ovf;
        logic                dz;
        logic                cerr;
        logic                pv;
        logic [WORD_W-1:0]   pval;
    } res_t;

    function automatic logic in_range(input logic signed [WORD_W:0] v);
        return (v <= LIM_POS) && (v >= LIM_NEG);
    endfunction

    // machine and sequencer state
    state_t                     state_reg, state_next;
    logic                       kind_reg, kind_next;
    logic [OP_W-1:0]            op_reg, op_next;
    logic [FIELD_AW-1:0]        addr_reg, addr_next;
    logic [WORD_W-1:0]          dv_reg, dv_next;
    logic signed [WORD_W-1:0]   acc_reg, acc_next;
    logic                       add_flag_reg, add_flag_next;
    logic                       halted_reg, halted_next;
    logic                       neg_reg, neg_next;
    logic                       is_div_reg, is_div_next;
    res_t                       res_reg, res_next;
    logic                       out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]       out_data_reg, out_data_next;

    // memory and unit hookup
    logic                       mem_rd_en;
    logic [ADDR_W-1:0]          mem_rd_addr;
    logic                       mem_wr_en;
    logic [WORD_W-1:0]          mem_wr_data;
    logic [WORD_W-1:0]          mem_rd_data;
    iter_req_t                  iter_req;
    iter_rsp_t                  iter_rsp;

    // datapath helpers
    logic                       addr_hit;
    logic signed [WORD_W-1:0]   m_word;
    logic signed [WORD_W:0]     acc_ext;
    logic signed [WORD_W:0]     m_ext;
    logic signed [WORD_W:0]     sum_add;
    logic signed [WORD_W:0]     sum_sub;
    logic signed [WORD_W:0]     sum_shl;
    logic [WORD_W-1:0]          acc_abs;
    logic [WORD_W-1:0]          m_abs;
    logic [WORD_W-1:0]          mag15;
    logic                       dv_ok;
    logic [FIELD_AW-1:0]        s_addr;

    assign s_addr   = s_tdata[2*OP_W-1:OP_W];
    assign addr_hit = ({1'b0, addr_reg} < DEPTH);
    assign m_word   = addr_hit ? mem_rd_data : '0;
    assign acc_ext  = {acc_reg[WORD_W-1], acc_reg};
    assign m_ext    = {m_word[WORD_W-1], m_word};
    assign sum_add  = acc_ext + m_ext;
    assign sum_sub  = acc_ext - m_ext;
    assign sum_shl  = {m_word, 1'b0};
    assign acc_abs  = acc_reg[WORD_W-1] ? (~acc_reg + WORD_W'(1)) : acc_reg;
    assign m_abs    = m_word[WORD_W-1] ? (~m_word + WORD_W'(1)) : m_word;
    assign dv_ok    = (dv_reg != MIN_WORD);

    // read is issued at acceptance so the word is there in ST_FETCH
    assign mem_rd_en   = (state_reg == ST_IDLE) && s_tvalid;
    assign mem_rd_addr = s_addr[ADDR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        dv_next        = dv_reg;
        acc_next       = acc_reg;
        add_flag_next  = add_flag_reg;
        halted_next    = halted_reg;
        neg_next       = neg_reg;
        is_div_next    = is_div_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        mem_wr_en      = 1'b0;
        mem_wr_data    = dv_reg;
        iter_req       = '0;
        iter_req.a_mag = acc_abs[MAG_W-1:0];
        iter_req.b_mag = m_abs[MAG_W-1:0];
        mag15          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next  = s_tuser;
                    op_next    = s_tdata[OP_W-1:0];
                    addr_next  = s_addr;
                    dv_next    = s_tdata[2*OP_W+WORD_W-1:2*OP_W];
                    res_next   = '0;
                    state_next = ST_FETCH;
                end
            end

            ST_FETCH:
            begin
                state_next = ST_DONE;
                if (!halted_reg)
                begin
                    if (kind_reg)
                    begin
                        // host preload; the value minus 16384 is dropped
                        mem_wr_en = dv_ok && addr_hit;
                    end
                    else
                    begin
                        unique case (op_reg)
                            OP_READ:
                            begin
                                mem_wr_en    = dv_ok && addr_hit;
                                res_next.ovf = !dv_ok;
                            end
                            OP_WRITE:
                            begin
                                res_next.pv   = 1'b1;
                                res_next.pval = m_word;
                            end
                            OP_LOAD:
                            begin
                                acc_next = m_word;
                            end
                            OP_STORE:
                            begin
                                mem_wr_en   = addr_hit;
                                mem_wr_data = acc_reg;
                            end
                            OP_ADD:
                            begin
                                if (in_range(sum_add))
                                begin
                                    acc_next      = sum_add[WORD_W-1:0];
                                    add_flag_next = 1'b1;
                                end
                                else
                                begin
                                    res_next.ovf = 1'b1;
                                end
                            end
                            OP_SUB:
                            begin
                                if (in_range(sum_sub))
                                begin
                                    acc_next = sum_sub[WORD_W-1:0];
                                end
                                else
                                begin
                                    res_next.ovf = 1'b1;
                                end
                            end
                            OP_SHL:
                            begin
                                if (in_range(sum_shl))
                                begin
                                    acc_next = sum_shl[WORD_W-1:0];
                                end
                                else
                                begin
                                    res_next.ovf = 1'b1;
                                end
                            end
                            OP_SHR:
                            begin
                                acc_next = m_word >>> 1;
                            end
                            OP_MUL:
                            begin
                                iter_req.start = 1'b1;
                                is_div_next    = 1'b0;
                                neg_next       = acc_reg[WORD_W-1] ^ m_word[WORD_W-1];
                                state_next     = ST_WAIT;
                            end
                            OP_DIV:
                            begin
                                if (m_word == '0)
                                begin
                                    res_next.dz = 1'b1;
                                end
                                else
                                begin
                                    iter_req.start  = 1'b1;
                                    iter_req.is_div = 1'b1;
                                    is_div_next     = 1'b1;
                                    neg_next   = acc_reg[WORD_W-1] ^ m_word[WORD_W-1];
                                    state_next = ST_WAIT;
                                end
                            end
                            OP_JUMP:
                            begin
                                res_next.jt = 1'b1;
                            end
                            OP_JNEG:
                            begin
                                res_next.jt = acc_reg[WORD_W-1];
                            end
                            OP_JZ:
                            begin
                                res_next.jt = (acc_reg == '0);
                            end
                            OP_JNS:
                            begin
                                res_next.jt = !acc_reg[WORD_W-1] && (acc_reg != '0);
                            end
                            OP_JP:
                            begin
                                res_next.jt = !acc_reg[0];
                            end
                            OP_JC:
                            begin
                                res_next.jt   = add_flag_reg;
                                add_flag_next = 1'b0;
                            end
                            OP_HALT:
                            begin
                                halted_next = 1'b1;
                            end
                            default:
                            begin
                                res_next.cerr = 1'b1;
                            end
                        endcase
                        if (res_next.ovf || res_next.dz || res_next.cerr)
                        begin
                            halted_next = 1'b1;
                        end
                        res_next.jtarget = res_next.jt ? addr_reg : '0;
                    end
                end
            end

            ST_WAIT:
            begin
                if (iter_rsp.done)
                begin
                    state_next = ST_DONE;
                    if (is_div_reg)
                    begin
                        mag15    = {1'b0, iter_rsp.quotient};
                        acc_next = neg_reg ? (~mag15 + WORD_W'(1)) : mag15;
                    end
                    else if (iter_rsp.product[2*MAG_W-1:MAG_W] != '0)
                    begin
                        // product magnitude above the limit
                        res_next.ovf = 1'b1;
                        halted_next  = 1'b1;
                    end
                    else
                    begin
                        mag15    = {1'b0, iter_rsp.product[MAG_W-1:0]};
                        acc_next = neg_reg ? (~mag15 + WORD_W'(1)) : mag15;
                    end
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {5'b0, res_reg.pval, res_reg.pv, halted_reg,
                                      res_reg.cerr, res_reg.dz, res_reg.ovf,
                                      res_reg.jtarget, res_reg.jt, acc_reg};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            add_flag_reg  <= 1'b0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            add_flag_reg  <= add_flag_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        dv_reg       <= dv_next;
        neg_reg      <= neg_next;
        is_div_reg   <= is_div_next;
        res_reg      <= res_next;
    end

    amx_mem #(
        .MEMORY_WORDS (MEMORY_WORDS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .wr_en   (mem_wr_en),
        .wr_addr (addr_reg[ADDR_W-1:0]),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    amx_iter u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (iter_req),
        .rsp   (iter_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire
